// ===== hw/rtl/prim_minimum_spanning_tree_unit_macros.svh =====
// Assertion macros shared by the spanning tree unit RTL.
`ifndef PRIM_MINIMUM_SPANNING_TREE_UNIT_MACROS_SVH
`define PRIM_MINIMUM_SPANNING_TREE_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PMST_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PMST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pmst_pkg.sv =====
// Types, constants and helper functions of the spanning tree unit.
package pmst_pkg;

    localparam int MAX_VERTICES = 16;

    localparam int VERTEX_W = 5;
    localparam int WEIGHT_W = 14;
    localparam int SUM_W    = 18;
    localparam int MODE_W   = 2;

    localparam int IDX_W      = $clog2(MAX_VERTICES);
    localparam int CNT_W      = $clog2(MAX_VERTICES + 1);
    localparam int NUM_W      = (CNT_W > VERTEX_W) ? CNT_W : VERTEX_W;
    localparam int CELL_DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int CELL_AW    = $clog2(CELL_DEPTH);
    localparam int CELL_W     = WEIGHT_W + 1;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 32;

    localparam logic [WEIGHT_W-1:0] UNREACHED = WEIGHT_W'(9999);
    localparam logic [VERTEX_W-1:0] VERTEX_COUNT_RESET = VERTEX_W'(16);
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN    = 2'd2;

    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MIRROR,
        ST_RELAX,
        ST_SELECT,
        ST_EMIT
    } state_t;

    // Number of vertices in use, with zero taken as one and large values clamped.
    function automatic logic [CNT_W-1:0] active_count(input logic [VERTEX_W-1:0] vc);
        logic [CNT_W-1:0] n;
        if (vc == '0) begin
            n = CNT_W'(1);
        end
        else if (NUM_W'(vc) > NUM_W'(MAX_VERTICES)) begin
            n = CNT_W'(MAX_VERTICES);
        end
        else begin
            n = CNT_W'(NUM_W'(vc));
        end
        return n;
    endfunction

    // Matrix address of the entry for row vertex a and column vertex b (zero based).
    function automatic logic [CELL_AW-1:0] cell_addr(input logic [IDX_W-1:0] a,
                                                     input logic [IDX_W-1:0] b);
        return CELL_AW'(CELL_AW'(a) * CELL_AW'(MAX_VERTICES)) + CELL_AW'(b);
    endfunction

    // Vertex number (one based) of a zero based index.
    function automatic logic [VERTEX_W-1:0] vertex_of(input logic [IDX_W-1:0] idx);
        return VERTEX_W'(NUM_W'(idx) + NUM_W'(1));
    endfunction

    // Zero based index of a vertex number that is known to be at least one.
    function automatic logic [IDX_W-1:0] index_of(input logic [VERTEX_W-1:0] v);
        return IDX_W'(NUM_W'(v) - NUM_W'(1));
    endfunction

endpackage

// ===== hw/rtl/pmst_req_if.sv =====
// Request channel: edge updates and run commands going into the unit.
interface pmst_req_if import pmst_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [VERTEX_W-1:0] first_vertex;
    logic [VERTEX_W-1:0] second_vertex;
    logic [WEIGHT_W-1:0] weight;

    modport source (
        output valid, mode, first_vertex, second_vertex, weight,
        input  ready
    );

    modport sink (
        input  valid, mode, first_vertex, second_vertex, weight,
        output ready
    );
endinterface

// ===== hw/rtl/pmst_rsp_if.sv =====
// Response channel: tree edges and the final total leaving the unit.
interface pmst_rsp_if import pmst_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [VERTEX_W-1:0] parent_vertex;
    logic [VERTEX_W-1:0] tree_vertex;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [SUM_W-1:0]    total_weight;
    logic                last;

    modport source (
        output valid, kind, parent_vertex, tree_vertex, edge_weight, total_weight, last,
        input  ready
    );

    modport sink (
        input  valid, kind, parent_vertex, tree_vertex, edge_weight, total_weight, last,
        output ready
    );
endinterface

// ===== hw/rtl/pmst_ram.sv =====
// Generic simple dual port RAM with one write port and a registered read port.
module pmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/prim_minimum_spanning_tree_unit.sv =====
// Top level: adjacency matrix store and Prim spanning tree sequencer with APB configuration.
// An insert or remove word makes one write per matrix direction, the second from ST_MIRROR.
// A run alternates a relax scan of the newest tree vertex's row and a select scan for the
// nearest vertex outside the tree, emits a word per tree edge and closes with the total;
// the single matrix read port paces the relax scan and the shared comparator the select scan.
// Reset: asynchronous, active low; afterwards all MAX_VERTICES^2 matrix entries (256 at 16
// vertices) are swept clear with the request channel held not ready.
module prim_minimum_spanning_tree_unit import pmst_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,

    pmst_req_if.sink          req,
    pmst_rsp_if.source        rsp
);

`include "prim_minimum_spanning_tree_unit_macros.svh"

    // ------------------------------------------------------------------
    // Configuration. There is a single register, so the address lines are
    // ignored and every write lands in vc_reg, the vertex count.
    // ------------------------------------------------------------------
    logic [VERTEX_W-1:0] vc_reg;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = {(CFG_DW - VERTEX_W)'(0), vc_reg} | CFG_DW'(paddr & '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= VERTEX_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            vc_reg <= pwdata[VERTEX_W-1:0];
        end
    end

    // Effective vertex count and the index of the last active vertex.
    logic [CNT_W-1:0] n_active;
    logic [IDX_W-1:0] n_last;

    assign n_active = active_count(vc_reg);
    assign n_last   = IDX_W'(n_active - CNT_W'(1));

    // ------------------------------------------------------------------
    // Adjacency matrix. Each word holds a presence bit above the weight.
    // After reset the whole matrix is written with zero, so a never written
    // entry reads as absent.
    // ------------------------------------------------------------------
    logic               ram_we;
    logic [CELL_AW-1:0] ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [CELL_AW-1:0] ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    pmst_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_DEPTH)
    ) u_matrix (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer state.
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [CELL_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [CELL_AW-1:0]  mirror_addr_reg, mirror_addr_next;
    logic [CELL_W-1:0]   mirror_data_reg, mirror_data_next;

    // Per-vertex work of a run.
    logic                done_reg   [MAX_VERTICES];
    logic                done_next  [MAX_VERTICES];
    logic [WEIGHT_W-1:0] dist_reg   [MAX_VERTICES];
    logic [WEIGHT_W-1:0] dist_next  [MAX_VERTICES];
    logic [VERTEX_W-1:0] parent_reg [MAX_VERTICES];
    logic [VERTEX_W-1:0] parent_next[MAX_VERTICES];
    logic [SUM_W-1:0]    sum_reg, sum_next;

    // The vertex just added, whose row of the matrix is being scanned.
    logic [IDX_W-1:0]    v_reg, v_next;

    // Relax scan: one matrix read issued per cycle, its result used the cycle after.
    logic                issue_on_reg, issue_on_next;
    logic [IDX_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;

    // Select scan: running minimum over the vertices not yet in the tree.
    logic [IDX_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic [WEIGHT_W-1:0] best_d_reg, best_d_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic                found_reg, found_next;

    // Output register, which lets the sequencer move on while a word waits.
    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg, out_kind_next;
    logic [VERTEX_W-1:0] out_parent_reg, out_parent_next;
    logic [VERTEX_W-1:0] out_vertex_reg, out_vertex_next;
    logic [WEIGHT_W-1:0] out_weight_reg, out_weight_next;
    logic [SUM_W-1:0]    out_total_reg, out_total_next;
    logic                out_last_reg, out_last_next;

    // The one shared comparator: less-than over two weights.
    logic [WEIGHT_W-1:0] cmp_a, cmp_b;
    logic                cmp_lt;

    assign cmp_lt = cmp_a < cmp_b;

    // Request decode.
    logic                edge_ok;
    logic [IDX_W-1:0]    a_idx, b_idx;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_sat;
    logic                out_free;

    assign a_idx   = index_of(req.first_vertex);
    assign b_idx   = index_of(req.second_vertex);
    assign edge_ok = (req.first_vertex != '0) && (req.second_vertex != '0)
                  && (NUM_W'(req.first_vertex) <= NUM_W'(n_active))
                  && (NUM_W'(req.second_vertex) <= NUM_W'(n_active));

    // Running tree weight with the candidate edge, saturating at the field maximum.
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(best_d_reg);
    assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);

    assign rsp.valid         = out_valid_reg;
    assign rsp.kind          = out_kind_reg;
    assign rsp.parent_vertex = out_parent_reg;
    assign rsp.tree_vertex   = out_vertex_reg;
    assign rsp.edge_weight   = out_weight_reg;
    assign rsp.total_weight  = out_total_reg;
    assign rsp.last          = out_last_reg;

    // ------------------------------------------------------------------
    // Next state and datapath control.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        mirror_addr_next = mirror_addr_reg;
        mirror_data_next = mirror_data_reg;
        done_next        = done_reg;
        dist_next        = dist_reg;
        parent_next      = parent_reg;
        sum_next         = sum_reg;
        v_next           = v_reg;
        issue_on_next    = issue_on_reg;
        rd_cnt_next      = rd_cnt_reg;
        pend_valid_next  = 1'b0;
        pend_idx_next    = pend_idx_reg;
        scan_cnt_next    = scan_cnt_reg;
        best_d_next      = best_d_reg;
        best_idx_next    = best_idx_reg;
        found_next       = found_reg;

        out_valid_next   = out_valid_reg && !rsp.ready;
        out_kind_next    = out_kind_reg;
        out_parent_next  = out_parent_reg;
        out_vertex_next  = out_vertex_reg;
        out_weight_next  = out_weight_reg;
        out_total_next   = out_total_reg;
        out_last_next    = out_last_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        cmp_a     = '0;
        cmp_b     = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == CELL_AW'(CELL_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + CELL_AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.mode)
                        MODE_INSERT, MODE_REMOVE:
                        begin
                            // Write one direction now and the mirror entry next cycle.
                            if (edge_ok)
                            begin
                                ram_we           = 1'b1;
                                ram_waddr        = cell_addr(a_idx, b_idx);
                                ram_wdata        = {req.mode == MODE_INSERT, req.weight};
                                mirror_addr_next = cell_addr(b_idx, a_idx);
                                mirror_data_next = {req.mode == MODE_INSERT, req.weight};
                                state_next       = ST_MIRROR;
                            end
                        end

                        MODE_RUN:
                        begin
                            for (int i = 0; i < MAX_VERTICES; i++)
                            begin
                                done_next[i]   = 1'b0;
                                dist_next[i]   = UNREACHED;
                                parent_next[i] = '0;
                            end
                            dist_next[0]  = '0;
                            sum_next      = '0;
                            v_next        = '0;
                            issue_on_next = 1'b1;
                            rd_cnt_next   = '0;
                            state_next    = ST_RELAX;
                        end

                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_MIRROR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = mirror_addr_reg;
                ram_wdata  = mirror_data_reg;
                state_next = ST_IDLE;
            end

            ST_RELAX:
            begin
                if (issue_on_reg)
                begin
                    ram_re          = 1'b1;
                    ram_raddr       = cell_addr(v_reg, rd_cnt_reg);
                    pend_valid_next = 1'b1;
                    pend_idx_next   = rd_cnt_reg;
                    if (rd_cnt_reg == n_last)
                    begin
                        issue_on_next = 1'b0;
                    end
                    else
                    begin
                        rd_cnt_next = rd_cnt_reg + IDX_W'(1);
                    end
                end

                cmp_a = ram_rdata[WEIGHT_W-1:0];
                cmp_b = dist_reg[pend_idx_reg];
                if (pend_valid_reg)
                begin
                    if (ram_rdata[WEIGHT_W] && !done_reg[pend_idx_reg] && cmp_lt)
                    begin
                        dist_next[pend_idx_reg]   = ram_rdata[WEIGHT_W-1:0];
                        parent_next[pend_idx_reg] = vertex_of(v_reg);
                    end
                    if (pend_idx_reg == n_last)
                    begin
                        done_next[v_reg] = 1'b1;
                        scan_cnt_next    = '0;
                        best_d_next      = UNREACHED;
                        best_idx_next    = '0;
                        found_next       = 1'b0;
                        state_next       = ST_SELECT;
                    end
                end
            end

            ST_SELECT:
            begin
                // Strict compare keeps the lowest index on ties.
                cmp_a = dist_reg[scan_cnt_reg];
                cmp_b = best_d_reg;
                if (!done_reg[scan_cnt_reg] && cmp_lt)
                begin
                    best_d_next   = dist_reg[scan_cnt_reg];
                    best_idx_next = scan_cnt_reg;
                    found_next    = 1'b1;
                end
                if (scan_cnt_reg == n_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + IDX_W'(1);
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (found_reg)
                    begin
                        out_kind_next   = KIND_EDGE;
                        out_parent_next = parent_reg[best_idx_reg];
                        out_vertex_next = vertex_of(best_idx_reg);
                        out_weight_next = best_d_reg;
                        out_total_next  = sum_sat;
                        out_last_next   = 1'b0;
                        sum_next        = sum_sat;
                        v_next          = best_idx_reg;
                        issue_on_next   = 1'b1;
                        rd_cnt_next     = '0;
                        state_next      = ST_RELAX;
                    end
                    else
                    begin
                        // Nothing reachable is left: close the run with the total.
                        out_kind_next   = KIND_TOTAL;
                        out_parent_next = '0;
                        out_vertex_next = '0;
                        out_weight_next = '0;
                        out_total_next  = sum_reg;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers. Control state is reset; payload is not.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            sum_reg        <= '0;
            issue_on_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                done_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            sum_reg        <= sum_next;
            issue_on_reg   <= issue_on_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mirror_addr_reg <= mirror_addr_next;
        mirror_data_reg <= mirror_data_next;
        dist_reg        <= dist_next;
        parent_reg      <= parent_next;
        v_reg           <= v_next;
        rd_cnt_reg      <= rd_cnt_next;
        pend_idx_reg    <= pend_idx_next;
        scan_cnt_reg    <= scan_cnt_next;
        best_d_reg      <= best_d_next;
        best_idx_reg    <= best_idx_next;
        out_kind_reg    <= out_kind_next;
        out_parent_reg  <= out_parent_next;
        out_vertex_reg  <= out_vertex_next;
        out_weight_reg  <= out_weight_next;
        out_total_reg   <= out_total_next;
        out_last_reg    <= out_last_next;
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A vertex chosen by the select scan must have been reached by some edge.
    `PMST_ASSERT_IMP(a_found_reached, (state_reg == ST_EMIT) && found_reg, best_d_reg != UNREACHED, "selected vertex has unreached distance")

    // An accepted run word starts a fresh relax scan of vertex 1.
    `PMST_ASSERT_NEXT(a_run_starts, req.valid && req.ready && (req.mode == MODE_RUN), (state_reg == ST_RELAX) && issue_on_reg && !pend_valid_reg && (v_reg == '0), "run did not start a relax scan")

    // A tree edge word always names two real vertices and never has last set.
    `PMST_ASSERT_IMP(a_edge_ids, rsp.valid && (rsp.kind == KIND_EDGE), (rsp.tree_vertex != '0) && (rsp.parent_vertex != '0) && !rsp.last, "tree edge word with a zero vertex or last set")

endmodule

// ===== verif/pmst_tree_check.sv =====
// Watches both channels and the register port, predicts every spanning tree word and compares.
module pmst_tree_check import pmst_pkg::*; #(
    parameter logic [CFG_AW-1:0] COUNT_ADDR = '0
) (
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    input  logic              pready,

    pmst_req_if               req,
    pmst_rsp_if               rsp,

    output int                failures,
    output int                outstanding,
    output int                runs,
    output int                words
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                kind;
        logic [VERTEX_W-1:0] parent;
        logic [VERTEX_W-1:0] vertex;
        logic [WEIGHT_W-1:0] weight;
        logic [SUM_W-1:0]    total;
        logic                last;
    } tree_word_t;

    // Shadow of the graph and of the vertex count register.
    logic [WEIGHT_W-1:0] weight_mem [1:MAX_VERTICES][1:MAX_VERTICES];
    bit                  link_mem   [1:MAX_VERTICES][1:MAX_VERTICES];
    logic [VERTEX_W-1:0] count_reg;

    tree_word_t tree_words_due [$];
    tree_word_t arrived;
    int         fail_total;
    int         runs_planned;
    int         words_seen;

    function automatic int unsigned vertices_in_use();
        if (count_reg == '0) return 1;
        if (count_reg > MAX_VERTICES) return MAX_VERTICES;
        return count_reg;
    endfunction

    // Grows the tree from vertex 1 and queues one word per tree edge, then the total.
    function automatic void grow_tree();
        bit          in_tree [1:MAX_VERTICES];
        int unsigned reach   [1:MAX_VERTICES];
        int unsigned via     [1:MAX_VERTICES];
        int unsigned n, cur, pick, near, sum;
        tree_word_t  word;
        n = vertices_in_use();
        for (int i = 1; i <= MAX_VERTICES; i++) begin
            in_tree[i] = 1'b0;
            reach[i] = UNREACHED;
            via[i] = 0;
        end
        reach[1] = 0;
        sum = 0;
        cur = 1;
        do begin
            for (int i = 1; i <= n; i++) begin
                if (link_mem[cur][i] && !in_tree[i] && reach[i] > weight_mem[cur][i]) begin
                    reach[i] = weight_mem[cur][i];
                    via[i] = cur;
                end
            end
            in_tree[cur] = 1'b1;
            // Strictly smaller wins, so a tie keeps the lowest index.
            near = UNREACHED;
            pick = 0;
            for (int i = 1; i <= n; i++) begin
                if (!in_tree[i] && reach[i] < near) begin
                    near = reach[i];
                    pick = i;
                end
            end
            if (pick != 0) begin
                cur = pick;
                sum = sum + near;
                if (sum > SUM_MAX) sum = SUM_MAX;
                word.kind = KIND_EDGE;
                word.parent = VERTEX_W'(via[cur]);
                word.vertex = VERTEX_W'(cur);
                word.weight = WEIGHT_W'(near);
                word.total = SUM_W'(sum);
                word.last = 1'b0;
                tree_words_due.push_back(word);
            end
        end while (pick != 0);
        word.kind = KIND_TOTAL;
        word.parent = '0;
        word.vertex = '0;
        word.weight = '0;
        word.total = SUM_W'(sum);
        word.last = 1'b1;
        tree_words_due.push_back(word);
        runs_planned++;
    endfunction

    function automatic void take_request(input logic [MODE_W-1:0] mode,
                                         input int unsigned a, input int unsigned b,
                                         input logic [WEIGHT_W-1:0] w);
        int unsigned n;
        n = vertices_in_use();
        if (mode == MODE_RUN) begin
            grow_tree();
            return;
        end
        if (mode != MODE_INSERT && mode != MODE_REMOVE) return;
        if (a < 1 || a > n || b < 1 || b > n) return;
        if (mode == MODE_INSERT) begin
            weight_mem[a][b] = w;
            weight_mem[b][a] = w;
        end
        link_mem[a][b] = (mode == MODE_INSERT);
        link_mem[b][a] = (mode == MODE_INSERT);
    endfunction

    task automatic report(input string what);
        fail_total++;
        if (fail_total <= 100) $display("MISMATCH at %0t ns, result word %0d: %s",
                                        $time, words_seen, what);
    endtask

    task automatic compare_word();
        tree_word_t want;
        if (tree_words_due.size() == 0) begin
            report($sformatf("word for vertex %0d arrived with nothing pending",
                             arrived.vertex));
            return;
        end
        want = tree_words_due.pop_front();
        if (arrived.kind !== want.kind)
            report($sformatf("kind %0d, expected %0d", arrived.kind, want.kind));
        if (arrived.parent !== want.parent)
            report($sformatf("parent_vertex %0d, expected %0d", arrived.parent, want.parent));
        if (arrived.vertex !== want.vertex)
            report($sformatf("tree_vertex %0d, expected %0d", arrived.vertex, want.vertex));
        if (arrived.weight !== want.weight)
            report($sformatf("edge_weight %0d, expected %0d", arrived.weight, want.weight));
        if (arrived.total !== want.total)
            report($sformatf("total_weight %0d, expected %0d", arrived.total, want.total));
        if (arrived.last !== want.last)
            report($sformatf("last %0d, expected %0d", arrived.last, want.last));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg = VERTEX_COUNT_RESET;
            for (int i = 1; i <= MAX_VERTICES; i++)
                for (int j = 1; j <= MAX_VERTICES; j++)
                    link_mem[i][j] = 1'b0;
            tree_words_due.delete();
            fail_total = 0;
            runs_planned = 0;
            words_seen = 0;
        end
        else begin
            if (psel && penable && pwrite && pready && paddr == COUNT_ADDR)
                count_reg = pwdata[VERTEX_W-1:0];
            // A word leaving now always belongs to a run accepted earlier.
            if (rsp.valid && rsp.ready) begin
                words_seen++;
                arrived.kind = rsp.kind;
                arrived.parent = rsp.parent_vertex;
                arrived.vertex = rsp.tree_vertex;
                arrived.weight = rsp.edge_weight;
                arrived.total = rsp.total_weight;
                arrived.last = rsp.last;
                compare_word();
            end
            if (req.valid && req.ready)
                take_request(req.mode, req.first_vertex, req.second_vertex, req.weight);
        end
        failures <= fail_total;
        outstanding <= tree_words_due.size();
        runs <= runs_planned;
        words <= words_seen;
    end

endmodule

// ===== verif/tb.sv =====
// Top of the spanning tree unit testbench: clock, reset, register writes and word traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pmst_pkg::*;

    // Register map: the vertex count is the only register.
    localparam logic [CFG_AW-1:0] REG_VERTEX_COUNT = CFG_AW'(0);
    // The mode field has one code the block does not define.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // The limit covers every word being a full 16 vertex run, with stalls on the result
    // side and every result word and every request word hit by the longest gap, several
    // times over, plus the matrix clearing pass after reset.
    localparam int CYCLE_LIMIT = 1_200_000;
    // An insert or remove word keeps the block busy through its mirror write and gives no
    // result, so a short pause covers it before a register write.
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 16;
    // Long enough for a run to fill the output side and back up the input.
    localparam int HOLD_CYCLES = 1500;

    localparam int NUM_PHASES = 7;
    int unsigned phase_count [NUM_PHASES] = '{9, 0, 31, 1, 5, 17, 12};
    int unsigned phase_words [NUM_PHASES] = '{40, 10, 40, 10, 30, 30, 40};

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    int fail_total;
    int words_outstanding;
    int runs_seen;
    int words_checked;
    int cycle_count = 0;
    int words_sent = 0;

    // Idle chances in percent, set per phase by the stimulus.
    int unsigned send_idle_pct = 25;
    int unsigned take_idle_pct = 25;
    // Each increment asks the result side for one long hold-off.
    int unsigned hold_requests = 0;

    pmst_req_if req_ch ();
    pmst_rsp_if rsp_ch ();

    prim_minimum_spanning_tree_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    pmst_tree_check #(
        .COUNT_ADDR (REG_VERTEX_COUNT)
    ) tree_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .failures    (fail_total),
        .outstanding (words_outstanding),
        .runs        (runs_seen),
        .words       (words_checked)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Most gaps are short, a few are long.
    function automatic int unsigned pick_gap();
        return ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    // Weights lean small so that ties between candidates are common. The heavy
    // ones at 9999 and above can never join a tree.
    function automatic int unsigned random_weight();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60) return $urandom_range(0, 40);
        if (roll < 88) return $urandom_range(0, 9998);
        if (roll < 93) return roll[0] ? 0 : 9998;
        return $urandom_range(9999, 16383);
    endfunction

    // Offers one request word, after an optional gap, and returns at the clock
    // edge that accepts it. Every call starts and ends on a rising edge.
    task automatic send_word(input logic [MODE_W-1:0] mode, input int unsigned a,
                             input int unsigned b, input int unsigned w);
        int unsigned gap;
        gap = ($urandom_range(99) < send_idle_pct) ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode <= mode;
        req_ch.first_vertex <= VERTEX_W'(a);
        req_ch.second_vertex <= VERTEX_W'(b);
        req_ch.weight <= WEIGHT_W'(w);
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        words_sent++;
    endtask

    // Setup cycle, then access cycle; the write lands when pready is seen.
    task automatic write_register(input logic [CFG_AW-1:0] addr, input int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= CFG_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Stops offering words and waits until every predicted result word has
    // been taken. The first edge lets the checker count a run accepted just now.
    task automatic wait_idle(input int unsigned extra);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_outstanding != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Random traffic for one vertex count setting. Most words are in-range
    // edge updates and runs; the rest are words the block must ignore, which
    // do not count toward the goal.
    task automatic random_phase(input int unsigned setting, input int unsigned goal);
        int unsigned n, counted, roll, a, b, far;
        n = (setting == 0) ? 1 : ((setting > MAX_VERTICES) ? MAX_VERTICES : setting);
        counted = 0;
        while (counted < goal)
        begin
            roll = $urandom_range(99);
            a = $urandom_range(1, n);
            b = $urandom_range(1, n);
            if (roll < 4)
            begin
                send_word(MODE_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
                          random_weight());
            end
            else if (roll < 12)
            begin
                // One end outside the vertices in use: zero or above the count.
                far = ($urandom_range(3) == 0) ? 0 : $urandom_range(n + 1, 31);
                if ($urandom_range(1) == 0) a = far;
                else b = far;
                send_word((roll < 8) ? MODE_INSERT : MODE_REMOVE, a, b, random_weight());
            end
            else
            begin
                if (roll < 27)
                    send_word(MODE_RUN, $urandom_range(0, 31), $urandom_range(0, 31),
                              random_weight());
                else if (roll < 40)
                    send_word(MODE_REMOVE, a, b, random_weight());
                else
                    send_word(MODE_INSERT, a, b, random_weight());
                counted++;
            end
        end
    endtask

    // Result side: ready drops for random stalls, and for a long hold-off
    // whenever the stimulus asks for one.
    initial
    begin : result_taker
        int unsigned stall_left, hold_left, holds_served;
        stall_left = 0;
        hold_left = 0;
        holds_served = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if ($urandom_range(99) < take_idle_pct)
            begin
                stall_left = pick_gap() - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d result words outstanding",
                 cycle_count, words_outstanding);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        req_ch.valid <= 1'b0;
        req_ch.mode <= MODE_INSERT;
        req_ch.first_vertex <= '0;
        req_ch.second_vertex <= '0;
        req_ch.weight <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset count of 16 vertices. The first word waits
        // out the clearing pass through the handshake.
        send_word(MODE_RUN, 0, 0, 0);              // empty graph: summary only
        send_word(MODE_INSERT, 1, 2, 0);           // lightest weight
        send_word(MODE_INSERT, 1, 16, 9998);       // highest vertex, heaviest usable weight
        send_word(MODE_INSERT, 16, 16, 5);         // self loop is stored, never used
        send_word(MODE_INSERT, 2, 3, 9999);        // heavy edge, never beats unreached
        send_word(MODE_INSERT, 3, 4, 16383);       // all weight bits set
        send_word(MODE_INSERT, 0, 5, 7);           // vertex zero is ignored
        send_word(MODE_INSERT, 5, 17, 7);          // vertex above the count is ignored
        send_word(MODE_REMOVE, 31, 31, 0);         // out of range remove is ignored
        send_word(MODE_UNUSED, 2, 5, 100);         // undefined mode does nothing
        send_word(MODE_RUN, 31, 31, 16383);        // fields of a run are ignored
        send_word(MODE_INSERT, 2, 1, 7);           // update from the other end
        send_word(MODE_INSERT, 1, 4, 3);
        send_word(MODE_INSERT, 1, 5, 3);           // tie with vertex 4: lower index first
        send_word(MODE_REMOVE, 16, 1, 0);          // vertex 16 now unreachable
        send_word(MODE_REMOVE, 6, 7, 0);           // removing a missing edge
        send_word(MODE_RUN, 0, 0, 0);
        send_word(MODE_INSERT, 2, 3, 6);           // heavy edge replaced by a light one
        send_word(MODE_RUN, 0, 0, 0);
        wait_idle(SETTLE_CYCLES);

        // Random phases over several counts, the out-of-range ones included.
        // Shrinking the count keeps edges to dropped vertices in the matrix.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_pct = $urandom_range(10, 50);
            take_idle_pct = $urandom_range(10, 50);
            write_register(REG_VERTEX_COUNT, phase_count[p]);
            random_phase(phase_count[p], phase_words[p]);
            wait_idle(SETTLE_CYCLES);
        end

        // Full count again, with back pressure.
        send_idle_pct = 30;
        take_idle_pct = 30;
        write_register(REG_VERTEX_COUNT, MAX_VERTICES);
        random_phase(MAX_VERTICES, 20);
        // The result side holds off while runs keep coming, so the block backs up.
        hold_requests <= hold_requests + 1;
        repeat (6) send_word(MODE_RUN, 0, 0, 0);
        // The request side pauses until every result word is out.
        wait_idle(0);
        // A stretch with no idling on either side.
        send_idle_pct = 0;
        take_idle_pct = 0;
        random_phase(MAX_VERTICES, 30);
        wait_idle(DRAIN_CYCLES);

        $display("Sent %0d request words over vertex counts 0, 1, 5, 9, 12, 16, 17 and 31;",
                 words_sent);
        $display("%0d spanning tree runs gave %0d result words, with a long output hold-off.",
                 runs_seen, words_checked);
        if (fail_total == 0 && words_outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pmst_pkg.sv
hw/rtl/pmst_req_if.sv
hw/rtl/pmst_rsp_if.sv
hw/rtl/pmst_ram.sv
hw/rtl/prim_minimum_spanning_tree_unit.sv
verif/pmst_tree_check.sv
verif/tb.sv
